// File: hw/rtl/image_zoom_2x_interpolate_defines.svh
`ifndef IMAGE_ZOOM_2X_INTERPOLATE_DEFINES_SVH
`define IMAGE_ZOOM_2X_INTERPOLATE_DEFINES_SVH

// Same-cycle implication check, gated by synchronous reset
`define IZM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check, gated by synchronous reset
`define IZM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/izm_pkg.sv
`default_nettype none

package izm_pkg;

  // Default geometry limits
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Fixed field widths
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int WIN_LO_W  = 10;
  localparam int OUT_W     = 11;
  localparam int CFG_IDX_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_BOTTOM   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_RIGHT    = 3'd5;

  // Register reset values
  localparam logic [CFG_W-1:0]    RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [CFG_W-1:0]    RST_IMAGE_HEIGHT = 11'd1024;
  localparam logic [WIN_LO_W-1:0] RST_WIN_TOP      = 10'd0;
  localparam logic [WIN_LO_W-1:0] RST_WIN_LEFT     = 10'd0;
  localparam logic [CFG_W-1:0]    RST_WIN_BOTTOM   = 11'd2;
  localparam logic [CFG_W-1:0]    RST_WIN_RIGHT    = 11'd2;

  // Neighborhood of one source pixel
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] upper_left;
    logic [PIX_W-1:0] above;
  } izm_nbr_t;

  // Interpolated values for the gaps around one source pixel
  typedef struct packed {
    logic [PIX_W-1:0] diag;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] lft;
  } izm_vals_t;

endpackage

`default_nettype wire

// File: hw/rtl/izm_interp.sv
`default_nettype none

module izm_interp (
  input  izm_pkg::izm_nbr_t  nbr,
  output izm_pkg::izm_vals_t vals
);
  import izm_pkg::*;

  logic [PIX_W:0] sum_h;
  logic [PIX_W:0] sum_v;
  logic [PIX_W:0] sum_u;
  logic [PIX_W:0] sum_d;
  logic [PIX_W-1:0] mean_u;

  // Average horizontal and vertical neighbors, and for the diagonal the mean of two pair means, truncated
  always_comb begin
    sum_h  = {1'b0, nbr.left} + {1'b0, nbr.pix};
    sum_v  = {1'b0, nbr.above} + {1'b0, nbr.pix};
    sum_u  = {1'b0, nbr.upper_left} + {1'b0, nbr.above};
    mean_u = sum_u[PIX_W:1];
    sum_d  = {1'b0, mean_u} + {1'b0, sum_h[PIX_W:1]};
    vals.lft  = sum_h[PIX_W:1];
    vals.up   = sum_v[PIX_W:1];
    vals.diag = sum_d[PIX_W:1];
  end

endmodule

`default_nettype wire

// File: hw/rtl/image_zoom_2x_interpolate.sv
// The first result of a window pixel is registered in the read stage and then in the emit stage.
// The single output port gives one result per cycle while out_ready is high; a window pixel
// gives 1 to 4 results, and a pixel outside the window gives none and does not wait for the emit stage.
// The line memory is read in the accept cycle and written when the pixel leaves the read stage.
// Reset (rst, synchronous): registers, counters and neighbor pixels return to their defaults;
// the line memory is not cleared and holds no data until a row has passed.
`default_nettype none

module image_zoom_2x_interpolate #(
  parameter int MAX_WIDTH  = izm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = izm_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration
  input  wire logic                           cfg_write,
  input  wire logic [izm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [izm_pkg::CFG_W-1:0]      cfg_data,
  // source pixels
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [izm_pkg::PIX_W-1:0]      pixel_in,
  // zoomed pixels
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [izm_pkg::PIX_W-1:0]           pixel_out,
  output logic [izm_pkg::OUT_W-1:0]           out_row,
  output logic [izm_pkg::OUT_W-1:0]           out_col,
  output logic                                last_in_run
);
  import izm_pkg::*;

`include "image_zoom_2x_interpolate_defines.svh"

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MAX_CR = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CMP_W  = ((MAX_CR > CFG_W) ? MAX_CR : CFG_W) + 1;

  // Configuration registers
  logic [CFG_W-1:0]    image_width;
  logic [CFG_W-1:0]    image_height;
  logic [WIN_LO_W-1:0] win_top;
  logic [WIN_LO_W-1:0] win_left;
  logic [CFG_W-1:0]    win_bottom;
  logic [CFG_W-1:0]    win_right;

  // Source position
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;

  // Read stage
  logic              s1_valid;
  logic [PIX_W-1:0]  s1_pix;
  logic [COL_W-1:0]  s1_col;
  logic              s1_hit;
  logic              s1_inz;
  logic              s1_jnz;
  logic [OUT_W-1:0]  s1_orow;
  logic [OUT_W-1:0]  s1_ocol;

  // Neighbor pixels
  logic [PIX_W-1:0] left_pixel;
  logic [PIX_W-1:0] upper_left_pixel;

  // Line memory
  logic [PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0] mem_rdata;
  logic [COL_W-1:0] rd_addr;
  logic             fwd;
  logic [PIX_W-1:0] fwd_pix;
  logic [PIX_W-1:0] above;

  // Emit stage
  logic [3:0]       e_mask;
  logic [3:0]       e_sel;
  logic [PIX_W-1:0] e_pix;
  izm_vals_t        e_vals;
  logic [OUT_W-1:0] e_orow;
  logic [OUT_W-1:0] e_ocol;

  // Combinational
  logic             in_acc;
  logic             out_acc;
  logic             emit_free;
  logic             s1_fire;
  logic [CMP_W-1:0] w_cfg;
  logic [CMP_W-1:0] h_cfg;
  logic [CMP_W-1:0] w_eff;
  logic [CMP_W-1:0] h_eff;
  logic [CMP_W-1:0] c_ext;
  logic [CMP_W-1:0] r_ext;
  logic [CMP_W-1:0] i_ext;
  logic [CMP_W-1:0] j_ext;
  logic             hit;
  logic [COL_W-1:0] col_pos_next;
  logic [ROW_W-1:0] row_pos_next;
  izm_nbr_t         nbr;
  izm_vals_t        vals;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      win_top      <= RST_WIN_TOP;
      win_left     <= RST_WIN_LEFT;
      win_bottom   <= RST_WIN_BOTTOM;
      win_right    <= RST_WIN_RIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_WIN_TOP:      win_top      <= cfg_data[WIN_LO_W-1:0];
        REG_WIN_LEFT:     win_left     <= cfg_data[WIN_LO_W-1:0];
        REG_WIN_BOTTOM:   win_bottom   <= cfg_data;
        REG_WIN_RIGHT:    win_right    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshakes and stage control
  always_comb begin
    e_sel     = e_mask & (~e_mask + 4'd1);
    out_valid = |e_mask;
    out_acc   = out_valid && out_ready;
    emit_free = (e_mask == 4'd0) || (out_ready && (e_mask == e_sel));
    s1_fire   = s1_valid && (!s1_hit || emit_free);
    in_ready  = !s1_valid || s1_fire;
    in_acc    = in_valid && in_ready;
  end

  // Clamp image size and locate the incoming pixel in the window
  always_comb begin
    w_cfg = CMP_W'(image_width);
    h_cfg = CMP_W'(image_height);
    if (w_cfg == '0) begin
      w_eff = CMP_W'(1);
    end else if (w_cfg > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg;
    end
    if (h_cfg == '0) begin
      h_eff = CMP_W'(1);
    end else if (h_cfg > CMP_W'(MAX_HEIGHT)) begin
      h_eff = CMP_W'(MAX_HEIGHT);
    end else begin
      h_eff = h_cfg;
    end
    c_ext = CMP_W'(col_pos);
    r_ext = CMP_W'(row_pos);
    hit   = (r_ext >= CMP_W'(win_top)) && (r_ext < CMP_W'(win_bottom)) &&
            (c_ext >= CMP_W'(win_left)) && (c_ext < CMP_W'(win_right));
    i_ext = r_ext - CMP_W'(win_top);
    j_ext = c_ext - CMP_W'(win_left);
    if (c_ext + CMP_W'(1) >= w_eff) begin
      col_pos_next = '0;
      row_pos_next = (r_ext + CMP_W'(1) >= h_eff) ? '0 : row_pos + ROW_W'(1);
    end else begin
      col_pos_next = col_pos + COL_W'(1);
      row_pos_next = row_pos;
    end
  end

  // Advance the source position on each input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (in_acc) begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
    end
  end

  // Read stage: hold the pixel while the memory read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix  <= pixel_in;
      s1_col  <= col_pos;
      s1_hit  <= hit;
      s1_inz  <= (i_ext != '0);
      s1_jnz  <= (j_ext != '0);
      s1_orow <= {i_ext[OUT_W-2:0], 1'b0};
      s1_ocol <= {j_ext[OUT_W-2:0], 1'b0};
    end
  end

  // Re-read the held column while stalled, else read the new column
  assign rd_addr = in_acc ? col_pos : s1_col;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      line_mem[s1_col] <= s1_pix;
    end
    mem_rdata <= line_mem[rd_addr];
  end

  // Forward a write that lands on the column read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= in_acc && s1_fire && (col_pos == s1_col);
    end
  end

  always_ff @(posedge clk) begin
    fwd_pix <= s1_pix;
  end

  assign above = fwd ? fwd_pix : mem_rdata;

  // Shift the neighbor pixels when the read stage retires
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else if (s1_fire) begin
      left_pixel       <= s1_pix;
      upper_left_pixel <= above;
    end
  end

  assign nbr.pix        = s1_pix;
  assign nbr.left       = left_pixel;
  assign nbr.upper_left = upper_left_pixel;
  assign nbr.above      = above;

  izm_interp u_interp (
    .nbr  (nbr),
    .vals (vals)
  );

  // Emit stage: one bit per pending result, drained lowest bit first
  always_ff @(posedge clk) begin
    if (rst) begin
      e_mask <= '0;
    end else if (s1_fire && s1_hit) begin
      e_mask <= {1'b1, s1_jnz, s1_inz, s1_inz & s1_jnz};
    end else if (out_acc) begin
      e_mask <= e_mask & ~e_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_hit) begin
      e_pix  <= s1_pix;
      e_vals <= vals;
      e_orow <= s1_orow;
      e_ocol <= s1_ocol;
    end
  end

  // Select the current result
  always_comb begin
    if (e_mask[0]) begin
      pixel_out = e_vals.diag;
      out_row   = e_orow - OUT_W'(1);
      out_col   = e_ocol - OUT_W'(1);
    end else if (e_mask[1]) begin
      pixel_out = e_vals.up;
      out_row   = e_orow - OUT_W'(1);
      out_col   = e_ocol;
    end else if (e_mask[2]) begin
      pixel_out = e_vals.lft;
      out_row   = e_orow;
      out_col   = e_ocol - OUT_W'(1);
    end else begin
      pixel_out = e_pix;
      out_row   = e_orow;
      out_col   = e_ocol;
    end
    last_in_run = (e_mask == e_sel);
  end

  // Checks
  `IZM_ASSERT_NOW(a_load_free, clk, rst, s1_fire && s1_hit, emit_free, "emit stage overwritten")
  `IZM_ASSERT_NOW(a_self_last, clk, rst, e_mask != 4'd0, e_mask[3], "source pixel result missing")
  `IZM_ASSERT_NOW(a_fwd_src, clk, rst, fwd, $past(s1_fire) && (s1_col == $past(s1_col)), "bad forward")

endmodule

`default_nettype wire
